FILE: rtl/event_period_statistics_core_assert.svh
// Assertion macros shared by the event period statistics front and back modules.
`ifndef EVENT_PERIOD_STATISTICS_CORE_ASSERT_SVH
`define EVENT_PERIOD_STATISTICS_CORE_ASSERT_SVH

// A condition that holds at every clock edge outside reset.
`define EVPS_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A consequence that holds in the same cycle as its antecedent.
`define EVPS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// A consequence that holds in the cycle after its antecedent.
`define EVPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/evps_pkg.sv
// Types and constants of the event period statistics block.
package evps_pkg;

   localparam int STAMP_W     = 63;
   localparam int CH_FIELD_W  = 2;
   localparam int CNT_OUT_W   = 11;
   localparam int CH_LIMIT    = 2 ** CH_FIELD_W;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   localparam logic [STAMP_W-1:0] STAMP_MAX = {STAMP_W{1'b1}};

   // Operation codes.
   localparam logic OP_MARK = 1'b0;
   localparam logic OP_READ = 1'b1;

   typedef struct packed {
      logic                  operation;
      logic [CH_FIELD_W-1:0] channel;
      logic [STAMP_W-1:0]    stamp_ns;
   } req_word_type;

   typedef struct packed {
      logic                 dropped;
      logic [CNT_OUT_W-1:0] sample_count;
      logic [STAMP_W-1:0]   min_period_ns;
      logic [STAMP_W-1:0]   max_period_ns;
      logic [STAMP_W-1:0]   avg_period_ns;
   } rsp_word_type;

   // A classified word as it waits between the front and the back.
   typedef struct packed {
      logic                  present;
      logic                  operation;
      logic [CH_FIELD_W-1:0] channel;
      logic [STAMP_W-1:0]    stamp_ns;
   } cmd_word_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_UPDATE,
      S_DIV
   } back_state_type;

endpackage

FILE: rtl/evps_front.sv
// Front end: accepts request words, classifies them and queues them for the back end.
`include "event_period_statistics_core_assert.svh"

module evps_front import evps_pkg::*; #(
   parameter int NUM_CHANNELS = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_push,
   input  req_word_type req_word,
   output logic         req_full,
   output logic         q_valid,
   output cmd_word_type q_word,
   input  logic         q_pop
);

   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   cmd_word_type      slot_ff [QUEUE_DEPTH];
   cmd_word_type      slot_in [QUEUE_DEPTH];
   cmd_word_type      cls_word;
   logic              push_ok;
   logic              pop_ok;

   // Classify the incoming word: a channel beyond the configured set is marked absent.
   always_comb begin
      cls_word.present   = (int'(req_word.channel) < NUM_CHANNELS);
      cls_word.operation = req_word.operation;
      cls_word.channel   = req_word.channel;
      cls_word.stamp_ns  = req_word.stamp_ns;
   end

   assign req_full = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign q_valid  = (count_ff != '0);
   assign q_word   = slot_ff[rd_ptr_ff];
   assign push_ok  = req_push & ~req_full;
   assign pop_ok   = q_pop & q_valid;

   // Queue pointers, fill count and slot writes.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      slot_in   = slot_ff;
      if (push_ok) begin
         slot_in[wr_ptr_ff] = cls_word;
         wr_ptr_in          = wr_ptr_ff + QPTR_W'(1);
      end
      if (pop_ok) begin
         rd_ptr_in = rd_ptr_ff + QPTR_W'(1);
      end
      if (push_ok && !pop_ok) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (!push_ok && pop_ok) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Slot contents are payload and need no reset.
   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   `EVPS_ASSERT_ALWAYS(a_fill_bound, clock, reset, count_ff <= QCNT_W'(QUEUE_DEPTH), "queue overfilled")
   `EVPS_ASSERT_IMPLY(a_ptr_gap, clock, reset, count_ff == '0, wr_ptr_ff == rd_ptr_ff, "pointers apart while empty")
   `EVPS_ASSERT_NEXT(a_push_grows, clock, reset, push_ok && !pop_ok, count_ff == $past(count_ff) + QCNT_W'(1), "push did not grow the queue")

endmodule

FILE: rtl/evps_divider.sv
// Restoring divider: one quotient bit per cycle for the window average.
module evps_divider import evps_pkg::*; #(
   parameter int DIVISOR_W = 11
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [STAMP_W-1:0]   dividend,
   input  logic [DIVISOR_W-1:0] divisor,
   output logic                 done,
   output logic [STAMP_W-1:0]   quotient
);

   localparam int STEP_W = $clog2(STAMP_W + 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic [DIVISOR_W-1:0] rem_ff, rem_in;
   logic [DIVISOR_W-1:0] div_ff, div_in;
   logic [STAMP_W-1:0]   quo_ff, quo_in;
   logic [DIVISOR_W:0]   shifted;
   logic [DIVISOR_W+1:0] trial;
   logic                 fits;

   // One trial subtraction of the divisor from the shifted partial remainder.
   always_comb begin
      shifted = {rem_ff, quo_ff[STAMP_W-1]};
      trial   = {1'b0, shifted} - {2'b00, div_ff};
      fits    = ~trial[DIVISOR_W+1];
   end

   // The quotient register first holds the dividend and fills with quotient bits.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         div_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in  = fits ? trial[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
         quo_in  = {quo_ff[STAMP_W-2:0], fits};
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(STAMP_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      div_ff <= div_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

FILE: rtl/evps_back.sv
// Back end: per-channel statistics state, command execution and the result register.
`include "event_period_statistics_core_assert.svh"

module evps_back import evps_pkg::*; #(
   parameter int NUM_CHANNELS = 4,
   parameter int WINDOW_DEPTH = 1024
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         q_valid,
   input  cmd_word_type q_word,
   output logic         q_pop,
   output logic         rsp_empty,
   output rsp_word_type rsp_word,
   input  logic         rsp_pop
);

   localparam int CH_STORE = (NUM_CHANNELS < CH_LIMIT) ? NUM_CHANNELS : CH_LIMIT;
   localparam int CH_IDX_W = (CH_STORE > 1) ? $clog2(CH_STORE) : 1;
   localparam int CNT_W    = $clog2(WINDOW_DEPTH + 1);

   back_state_type     state_ff, state_in;
   cmd_word_type       cmd_ff, cmd_in;
   logic [STAMP_W-1:0] iv_ff, iv_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_word_type       rsp_ff, rsp_in;

   logic [STAMP_W-1:0] last_ff [CH_STORE];
   logic [STAMP_W-1:0] last_in [CH_STORE];
   logic [CNT_W-1:0]   cnt_ff  [CH_STORE];
   logic [CNT_W-1:0]   cnt_in  [CH_STORE];
   logic [STAMP_W-1:0] sum_ff  [CH_STORE];
   logic [STAMP_W-1:0] sum_in  [CH_STORE];
   logic [STAMP_W-1:0] min_ff  [CH_STORE];
   logic [STAMP_W-1:0] min_in  [CH_STORE];
   logic [STAMP_W-1:0] max_ff  [CH_STORE];
   logic [STAMP_W-1:0] max_in  [CH_STORE];

   logic [CH_IDX_W-1:0] idx;
   logic [CNT_W-1:0]    cur_cnt;
   logic                win_full;
   logic [STAMP_W:0]    diff;
   logic [STAMP_W:0]    sum_wide;
   logic                div_start;
   logic                div_done;
   logic [STAMP_W-1:0]  div_quo;

   // The channel that the current command addresses; absent channels touch no state.
   assign idx      = cmd_ff.present ? cmd_ff.channel[CH_IDX_W-1:0] : '0;
   assign cur_cnt  = cnt_ff[idx];
   assign win_full = (cur_cnt >= CNT_W'(WINDOW_DEPTH));
   assign diff     = {1'b0, cmd_ff.stamp_ns} - {1'b0, last_ff[idx]};
   assign sum_wide = {1'b0, sum_ff[idx]} + {1'b0, iv_ff};

   // Next state of the command sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (q_valid && !rsp_valid_ff) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (!cmd_ff.present) begin
               state_in = S_IDLE;
            end else if (cmd_ff.operation == OP_MARK) begin
               state_in = win_full ? S_IDLE : S_UPDATE;
            end else begin
               state_in = (cur_cnt == '0) ? S_IDLE : S_DIV;
            end
         end
         S_UPDATE: begin
            state_in = S_IDLE;
         end
         S_DIV: begin
            if (div_done) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Handshake outputs of the sequencer.
   always_comb begin
      q_pop     = 1'b0;
      div_start = 1'b0;
      case (state_ff)
         S_IDLE: begin
            q_pop = q_valid & ~rsp_valid_ff;
         end
         S_EXEC: begin
            div_start = cmd_ff.present & (cmd_ff.operation == OP_READ) & (cur_cnt != '0);
         end
         default: begin
            q_pop     = 1'b0;
            div_start = 1'b0;
         end
      endcase
   end

   // Statistics updates and result assembly.
   always_comb begin
      cmd_in       = cmd_ff;
      iv_in        = iv_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_pop;
      last_in      = last_ff;
      cnt_in       = cnt_ff;
      sum_in       = sum_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      case (state_ff)
         S_IDLE: begin
            if (q_pop) begin
               cmd_in = q_word;
            end
         end
         S_EXEC: begin
            rsp_in = '0;
            if (!cmd_ff.present) begin
               rsp_valid_in = 1'b1;
            end else if (cmd_ff.operation == OP_MARK) begin
               // A missing earlier stamp or a stamp that went backward gives a zero interval.
               iv_in = ((last_ff[idx] != '0) && !diff[STAMP_W]) ? diff[STAMP_W-1:0] : '0;
               if (win_full) begin
                  rsp_in.dropped = 1'b1;
                  rsp_valid_in   = 1'b1;
               end
            end else begin
               rsp_in.sample_count = CNT_OUT_W'(cur_cnt);
               if (cur_cnt != '0) begin
                  rsp_in.min_period_ns = min_ff[idx];
                  rsp_in.max_period_ns = max_ff[idx];
               end else begin
                  rsp_valid_in = 1'b1;
               end
               // The divider has latched the sum, so the window clears now.
               cnt_in[idx] = '0;
               sum_in[idx] = '0;
               min_in[idx] = '0;
               max_in[idx] = '0;
            end
         end
         S_UPDATE: begin
            sum_in[idx] = sum_wide[STAMP_W] ? STAMP_MAX : sum_wide[STAMP_W-1:0];
            if (cur_cnt == '0) begin
               min_in[idx] = iv_ff;
               max_in[idx] = iv_ff;
            end else begin
               if (iv_ff < min_ff[idx]) begin
                  min_in[idx] = iv_ff;
               end
               if (iv_ff > max_ff[idx]) begin
                  max_in[idx] = iv_ff;
               end
            end
            cnt_in[idx]  = cur_cnt + CNT_W'(1);
            last_in[idx] = cmd_ff.stamp_ns;
            rsp_valid_in = 1'b1;
         end
         S_DIV: begin
            if (div_done) begin
               rsp_in.avg_period_ns = div_quo;
               rsp_valid_in         = 1'b1;
            end
         end
         default: begin
            rsp_valid_in = rsp_valid_ff & ~rsp_pop;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < CH_STORE; c++) begin
            last_ff[c] <= '0;
            cnt_ff[c]  <= '0;
            sum_ff[c]  <= '0;
            min_ff[c]  <= '0;
            max_ff[c]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         last_ff      <= last_in;
         cnt_ff       <= cnt_in;
         sum_ff       <= sum_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
      end
   end

   // Command, interval and result payload.
   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      iv_ff  <= iv_in;
      rsp_ff <= rsp_in;
   end

   evps_divider #(
      .DIVISOR_W (CNT_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff[idx]),
      .divisor  (cur_cnt),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign rsp_empty = ~rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   `EVPS_ASSERT_IMPLY(a_done_in_div, clock, reset, div_done, state_ff == S_DIV, "divider finished outside the divide step")
   `EVPS_ASSERT_IMPLY(a_slot_free, clock, reset, state_ff != S_IDLE, !rsp_valid_ff, "result slot busy while a word is in flight")
   `EVPS_ASSERT_IMPLY(a_drop_clean, clock, reset, rsp_valid_ff && rsp_ff.dropped, rsp_ff.sample_count == '0, "dropped result carries a count")
   `EVPS_ASSERT_ALWAYS(a_window_bound, clock, reset, cnt_ff[0] <= CNT_W'(WINDOW_DEPTH), "window count beyond depth")

endmodule

FILE: rtl/event_period_statistics_core.sv
// Top level of the per-channel event period statistics block.
//
//   channel   ports                            moves one word when
//   -------   ------------------------------   ----------------------------
//   request   req_push, req_full, req_word      req_push high, req_full low
//   result    rsp_pop, rsp_empty, rsp_word      rsp_pop high, rsp_empty low
//
// A mark passes from the head of the request queue through the execute and update
// steps to its result. A read with a nonempty window waits in the divide step for the
// divider, which produces one of the 63 quotient bits per cycle.
// Reset is synchronous and clears all channel statistics and last stamps at once.
// The two-word request queue keeps accepting while the back end works or while
// a finished result waits to be popped; the back end starts a new word only
// once the result register is free.
module event_period_statistics_core import evps_pkg::*; #(
   parameter int NUM_CHANNELS = 4,
   parameter int WINDOW_DEPTH = 1024
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_push,
   output logic         req_full,
   input  req_word_type req_word,
   output logic         rsp_empty,
   input  logic         rsp_pop,
   output rsp_word_type rsp_word
);

   logic         q_valid;
   logic         q_pop;
   cmd_word_type q_word;

   // Front end with its request queue.
   evps_front #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_word (req_word),
      .req_full (req_full),
      .q_valid  (q_valid),
      .q_word   (q_word),
      .q_pop    (q_pop)
   );

   // Back end with the statistics state and the result register.
   evps_back #(
      .NUM_CHANNELS (NUM_CHANNELS),
      .WINDOW_DEPTH (WINDOW_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_word    (q_word),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_word  (rsp_word),
      .rsp_pop   (rsp_pop)
   );

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for the per-channel event period statistics core.
`timescale 1ns / 1ps

module testbench;
   import evps_pkg::*;

   localparam int NUM_CH      = 4;
   localparam int WINDOW      = 1024;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_WAIT  = 200;
   localparam int CYCLE_LIMIT = 400000;

   localparam rsp_word_type NO_STATS = '0;

   typedef struct {
      req_word_type word;
      logic         typed;
      rsp_word_type want;
   } stim_row_type;

   logic         clock;
   logic         reset;
   logic         req_push;
   logic         req_full;
   req_word_type req_word;
   logic         rsp_empty;
   logic         rsp_pop;
   rsp_word_type rsp_word;

   // Predicted statistics of each channel.
   logic [STAMP_W-1:0] prev_stamp [CH_LIMIT];
   int unsigned        win_count  [CH_LIMIT];
   logic [STAMP_W-1:0] iv_sum     [CH_LIMIT];
   logic [STAMP_W-1:0] iv_min     [CH_LIMIT];
   logic [STAMP_W-1:0] iv_max     [CH_LIMIT];

   // Last stamp sent on each channel, used to build rising stamps.
   logic [STAMP_W-1:0] stim_time  [CH_LIMIT];

   rsp_word_type pending_stats[$];
   stim_row_type plan[$];
   int           mismatch_count = 0;
   int           cycle_count;
   int           gap_odds;
   logic         quiet;
   logic         hold_start;

   event_period_statistics_core #(
      .NUM_CHANNELS(NUM_CH),
      .WINDOW_DEPTH(WINDOW)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_word (req_word),
      .rsp_empty(rsp_empty),
      .rsp_pop  (rsp_pop),
      .rsp_word (rsp_word)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
   end

   // Watchdog on the total run length.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb: failure");
      $finish;
   end

   // Applies one request word to the predicted channel state and returns its result word.
   function automatic rsp_word_type tally_word(input req_word_type w);
      rsp_word_type       r;
      logic [STAMP_W-1:0] gap;
      int                 c;
      r = '0;
      c = int'(w.channel);
      if (c >= NUM_CH) return r;
      if (w.operation == OP_MARK) begin
         if (win_count[c] >= WINDOW) begin
            r.dropped = 1'b1;
            return r;
         end
         // No earlier event or a stamp that went backward gives a zero interval.
         gap = '0;
         if (prev_stamp[c] != '0 && w.stamp_ns > prev_stamp[c]) gap = w.stamp_ns - prev_stamp[c];
         if (iv_sum[c] > STAMP_MAX - gap) iv_sum[c] = STAMP_MAX;
         else iv_sum[c] = iv_sum[c] + gap;
         if (win_count[c] == 0) begin
            iv_min[c] = gap;
            iv_max[c] = gap;
         end else begin
            if (gap < iv_min[c]) iv_min[c] = gap;
            if (gap > iv_max[c]) iv_max[c] = gap;
         end
         win_count[c]++;
         prev_stamp[c] = w.stamp_ns;
      end else begin
         r.sample_count = CNT_OUT_W'(win_count[c]);
         if (win_count[c] != 0) begin
            r.min_period_ns = iv_min[c];
            r.max_period_ns = iv_max[c];
            r.avg_period_ns = iv_sum[c] / STAMP_W'(win_count[c]);
         end
         // The read clears the window but keeps the last stamp.
         win_count[c] = 0;
         iv_sum[c]    = '0;
         iv_min[c]    = '0;
         iv_max[c]    = '0;
      end
      return r;
   endfunction

   task automatic flag_mismatch(input string what);
      if (mismatch_count < 100) $display("[%0t] mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   task automatic check_result(input rsp_word_type got);
      rsp_word_type want;
      if (pending_stats.size() == 0) begin
         flag_mismatch("result word arrived with nothing pending");
         return;
      end
      want = pending_stats.pop_front();
      if (got.dropped !== want.dropped)
         flag_mismatch($sformatf("dropped %0d, expected %0d", got.dropped, want.dropped));
      if (got.sample_count !== want.sample_count)
         flag_mismatch($sformatf("sample_count %0d, expected %0d",
                                 got.sample_count, want.sample_count));
      if (got.min_period_ns !== want.min_period_ns)
         flag_mismatch($sformatf("min_period_ns %0d, expected %0d",
                                 got.min_period_ns, want.min_period_ns));
      if (got.max_period_ns !== want.max_period_ns)
         flag_mismatch($sformatf("max_period_ns %0d, expected %0d",
                                 got.max_period_ns, want.max_period_ns));
      if (got.avg_period_ns !== want.avg_period_ns)
         flag_mismatch($sformatf("avg_period_ns %0d, expected %0d",
                                 got.avg_period_ns, want.avg_period_ns));
   endtask

   function automatic logic [STAMP_W-1:0] random63();
      return STAMP_W'({$urandom(), $urandom()});
   endfunction

   function automatic req_word_type make_word(input logic op, input int ch,
                                              input logic [STAMP_W-1:0] stamp);
      req_word_type w;
      w.operation = op;
      w.channel   = CH_FIELD_W'(ch);
      w.stamp_ns  = stamp;
      return w;
   endfunction

   function automatic req_word_type noise_word();
      return make_word(logic'($urandom_range(1, 0)), $urandom_range(CH_LIMIT - 1, 0), random63());
   endfunction

   // Mostly rising stamps at several scales, with an occasional zero or arbitrary stamp.
   function automatic logic [STAMP_W-1:0] next_stamp(input int ch);
      logic [STAMP_W-1:0] step;
      logic [STAMP_W-1:0] s;
      case ($urandom_range(15, 0))
         0: s = random63();
         1: s = '0;
         default: begin
            case ($urandom_range(3, 0))
               0: step = STAMP_W'($urandom_range(2000, 1));
               1: step = STAMP_W'($urandom());
               2: step = STAMP_W'({16'($urandom()), $urandom()});
               default: step = random63() >> 2;
            endcase
            s = stim_time[ch] + step;
            // Past the top of the stamp range, start low again.
            if (s < stim_time[ch]) s = step;
         end
      endcase
      stim_time[ch] = s;
      return s;
   endfunction

   task automatic add_row(input logic op, input int ch, input logic [STAMP_W-1:0] stamp,
                          input logic typed, input rsp_word_type want);
      stim_row_type row;
      row.word  = make_word(op, ch, stamp);
      row.typed = typed;
      row.want  = want;
      plan.push_back(row);
   endtask

   // Offers one word until it is taken, then records its expected result.
   task automatic send_word(input req_word_type w, input logic typed,
                            input rsp_word_type typed_want, output rsp_word_type want);
      req_word <= w;
      req_push <= 1'b1;
      do @(posedge clock); while (req_full);
      want = tally_word(w);
      if (typed) pending_stats.push_back(typed_want);
      else pending_stats.push_back(want);
      if (!quiet && gap_odds != 0 && $urandom_range(gap_odds - 1, 0) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(16, 1)) @(posedge clock);
      end
   endtask

   task automatic pick_gap_odds();
      case ($urandom_range(3, 0))
         0: gap_odds = 0;
         1: gap_odds = 2;
         2: gap_odds = 5;
         default: gap_odds = 12;
      endcase
   endtask

   // A run of marks on one channel with some stray words, closed by a read.
   task automatic run_episode();
      int           ch;
      int           marks;
      rsp_word_type want;
      ch    = $urandom_range(CH_LIMIT - 1, 0);
      marks = $urandom_range(12, 0);
      pick_gap_odds();
      repeat (marks) begin
         if ($urandom_range(6, 0) == 0) send_word(noise_word(), 1'b0, NO_STATS, want);
         send_word(make_word(OP_MARK, ch, next_stamp(ch)), 1'b0, NO_STATS, want);
      end
      send_word(make_word(OP_READ, ch, random63()), 1'b0, NO_STATS, want);
   endtask

   // Fills one channel's window until several marks are dropped, then reads it.
   task automatic run_flood();
      int           ch;
      int           drops;
      int           sent;
      req_word_type w;
      rsp_word_type want;
      ch    = $urandom_range(CH_LIMIT - 1, 0);
      drops = 0;
      sent  = 0;
      // The result side holds off while words keep coming, so the input backs up.
      gap_odds   = 0;
      hold_start = 1'b1;
      while (drops < 5) begin
         if (sent == 150) gap_odds = 6;
         if ($urandom_range(19, 0) == 0) begin
            w = noise_word();
            w.channel = CH_FIELD_W'((ch + $urandom_range(CH_LIMIT - 1, 1)) % CH_LIMIT);
            send_word(w, 1'b0, NO_STATS, want);
         end
         send_word(make_word(OP_MARK, ch, next_stamp(ch)), 1'b0, NO_STATS, want);
         if (want.dropped) drops++;
         sent++;
      end
      send_word(make_word(OP_READ, ch, '0), 1'b0, NO_STATS, want);
   endtask

   // Result side: random stalls, a long hold-off on request, and checking.
   initial begin
      int   stall_left;
      int   hold_left;
      int   stall_odds;
      int   beat;
      logic hold_used;
      rsp_pop    = 1'b0;
      stall_left = 0;
      hold_left  = 0;
      stall_odds = 4;
      beat       = 0;
      hold_used  = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_pop && !rsp_empty) check_result(rsp_word);
         // The hold-off runs once, when the request side asks for it.
         if (hold_start && !hold_used) begin
            hold_left = HOLD_CYCLES;
            hold_used = 1'b1;
         end
         beat++;
         if (beat % 150 == 0) stall_odds = $urandom_range(1, 0) ? 0 : $urandom_range(8, 2);
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_pop <= 1'b0;
         end else if (!quiet && stall_odds != 0 && $urandom_range(stall_odds - 1, 0) == 0) begin
            stall_left = $urandom_range(16, 1) - 1;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   // Request side: directed table, random episodes, one flood, then a quiet tail.
   initial begin
      rsp_word_type want;
      for (int c = 0; c < CH_LIMIT; c++) begin
         prev_stamp[c] = '0;
         win_count[c]  = 0;
         iv_sum[c]     = '0;
         iv_min[c]     = '0;
         iv_max[c]     = '0;
         stim_time[c]  = '0;
      end
      req_push       = 1'b0;
      req_word       = '0;
      quiet          = 1'b0;
      hold_start     = 1'b0;
      gap_odds       = 3;

      // Channel 0: read after reset, zero stamp, first event, backward stamp, re-read.
      add_row(OP_READ, 0, '0, 1'b1, NO_STATS);
      add_row(OP_MARK, 0, '0, 1'b1, NO_STATS);
      add_row(OP_MARK, 0, 63'd100, 1'b1, NO_STATS);
      add_row(OP_MARK, 0, 63'd250, 1'b1, NO_STATS);
      add_row(OP_MARK, 0, 63'd200, 1'b1, NO_STATS);
      add_row(OP_READ, 0, '0, 1'b1, rsp_word_type'{1'b0, 11'd4, 63'd0, 63'd150, 63'd37});
      add_row(OP_READ, 0, '0, 1'b1, NO_STATS);
      add_row(OP_MARK, 0, 63'd260, 1'b1, NO_STATS);
      add_row(OP_READ, 0, '0, 1'b1, rsp_word_type'{1'b0, 11'd1, 63'd60, 63'd60, 63'd60});
      // Channel 1: two near-full intervals make the sum saturate.
      add_row(OP_MARK, 1, 63'd1, 1'b1, NO_STATS);
      add_row(OP_MARK, 1, STAMP_MAX, 1'b1, NO_STATS);
      add_row(OP_MARK, 1, 63'd1, 1'b1, NO_STATS);
      add_row(OP_MARK, 1, STAMP_MAX, 1'b1, NO_STATS);
      add_row(OP_READ, 1, '0, 1'b0, NO_STATS);
      // Channel 3: alternating bit patterns in the stamp.
      add_row(OP_MARK, 3, STAMP_MAX - STAMP_MAX / 3, 1'b1, NO_STATS);
      add_row(OP_MARK, 3, STAMP_MAX / 3, 1'b1, NO_STATS);
      add_row(OP_MARK, 3, STAMP_MAX, 1'b1, NO_STATS);
      add_row(OP_READ, 3, '0, 1'b0, NO_STATS);
      // Channel 2: the stamp field of a read is ignored.
      add_row(OP_MARK, 2, 63'd5, 1'b1, NO_STATS);
      add_row(OP_MARK, 2, 63'd12, 1'b1, NO_STATS);
      add_row(OP_READ, 2, STAMP_MAX, 1'b1, rsp_word_type'{1'b0, 11'd2, 63'd0, 63'd7, 63'd3});

      wait (reset == 1'b0);
      @(posedge clock);

      foreach (plan[i]) send_word(plan[i].word, plan[i].typed, plan[i].want, want);

      repeat (12) run_episode();
      run_flood();

      // Let everything drain before going on.
      req_push <= 1'b0;
      while (pending_stats.size() != 0) @(posedge clock);

      repeat (6) run_episode();
      quiet = 1'b1;
      repeat (12) run_episode();

      req_push <= 1'b0;
      while (pending_stats.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
